>>> hdl/isub_pkg.sv
// ============================================================================
// isub_pkg
// Shared constants, codes and types of the interval subscription matcher.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package isub_pkg;

  // Defaults of the top-level parameters.
  localparam int MaxSubsDefault        = 256;
  localparam int MaxConstraintsDefault = 8;
  localparam int NumAttrsDefault       = 32;

  // Fixed field widths.
  localparam int SubIdW  = 8;
  localparam int AttrW   = 5;
  localparam int BoundW  = 16;
  localparam int MatchW  = 9;
  localparam int StatusW = 2;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_EVENT  = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_INSERT_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_EVENT     = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  // One stored interval constraint.
  typedef struct packed {
    logic [AttrW-1:0]  attr;
    logic [BoundW-1:0] lo;
    logic [BoundW-1:0] hi;
  } constr_t;

endpackage

`default_nettype wire

>>> hdl/interval_subscription_matcher.sv
// ============================================================================
// interval_subscription_matcher
// Stores interval constraints per subscription and counts the subscriptions
// that a finished event satisfies.
// ============================================================================
// Usage: a word is taken at a rising edge where start_i is high and busy_o is
// low. cmd_i low inserts one constraint (attribute, low, high) into
// subscription sub_id_i; cmd_i high gives one event attribute value, and
// last_i closes the event. Results appear for exactly one cycle with done_o
// high; the receiver cannot stall them.
// An insert produces its result by way of the S_INS state (status 0, or 2
// when the list is full or the subscription number is out of range).
// An event pair without last_i is stored and gives no result.
// The closing pair starts a scan of all MAX_SUBS * MAX_CONSTRAINTS entries
// of the constraint memory, one constraint entry per cycle, set by the single
// read port of that memory; the read pipeline drains after it. busy_o stays high
// during the scan; the event values are forgotten when the count is given.
// After reset the block sweeps the count memory to zero, with busy_o high,
// before it takes the first word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module interval_subscription_matcher
  import isub_pkg::*;
#(
  parameter int MAX_SUBS        = MaxSubsDefault,
  parameter int MAX_CONSTRAINTS = MaxConstraintsDefault,
  parameter int NUM_ATTRS       = NumAttrsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                cmd_i,
  input  wire logic [SubIdW-1:0]   sub_id_i,
  input  wire logic [AttrW-1:0]    attribute_i,
  input  wire logic [BoundW-1:0]   low_bound_i,
  input  wire logic [BoundW-1:0]   high_bound_i,
  input  wire logic [BoundW-1:0]   event_value_i,
  input  wire logic                last_i,
  output logic                     done_o,
  output logic [MatchW-1:0]        match_count_o,
  output logic [StatusW-1:0]       status_o
);

  localparam int SW   = $clog2(MAX_SUBS);
  localparam int KW   = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int NW   = $clog2(MAX_CONSTRAINTS + 1);
  localparam int AW   = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int CNTW = $clog2(MAX_SUBS + 1);
  localparam int TD   = MAX_SUBS << KW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  // Memories.
  constr_t         tbl_mem [TD];
  logic [NW-1:0]   cnt_mem [MAX_SUBS];
  logic [BoundW-1:0] ev_mem [NUM_ATTRS];

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       s_q, s_d;
  logic [KW-1:0]       k_q, k_d;
  logic [NUM_ATTRS-1:0] given_q, given_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic                acc_q, acc_d;
  logic                done_q, done_d;
  logic [MatchW-1:0]   match_q, match_d;
  logic [StatusW-1:0]  status_q, status_d;

  // Insert payload.
  logic [SW-1:0]       ins_sid_q;
  logic                ins_ok_q;
  constr_t             ins_c_q;

  // Memory ports.
  constr_t             tbl_rdata_q;
  logic [NW-1:0]       cnt_rdata_q;
  logic [BoundW-1:0]   ev_rdata_q;
  logic [SW-1:0]       cnt_raddr;
  logic                cnt_we;
  logic [SW-1:0]       cnt_waddr;
  logic [NW-1:0]       cnt_wdata;
  logic                tbl_we;
  logic                ev_we;
  logic [AW-1:0]       ev_raddr;

  // Scan pipeline.
  logic                v1_q, v2_q;
  logic [KW-1:0]       k1_q;
  logic                first1_q, last1_q;
  logic                first2_q, last2_q, act2_q, nz2_q, ok2_q;
  logic [BoundW-1:0]   lo2_q, hi2_q;

  logic                accept;
  logic                k_last;
  logic                ins_full;
  logic                pass;
  logic                acc_new;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign k_last = (k_q == KW'(MAX_CONSTRAINTS - 1));
  assign ins_full = !ins_ok_q || (32'(cnt_rdata_q) >= MAX_CONSTRAINTS);

  assign cnt_raddr = (state_q == S_IDLE) ? SW'(sub_id_i) : s_q;
  assign ev_raddr  = AW'(tbl_rdata_q.attr);
  assign ev_we     = accept && (cmd_i == CMD_EVENT) && (32'(attribute_i) < NUM_ATTRS);
  assign tbl_we    = (state_q == S_INS) && !ins_full;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = s_q;
    cnt_wdata = '0;
    if (state_q == S_CLEAR) begin
      cnt_we = 1'b1;
    end else if (tbl_we) begin
      cnt_we    = 1'b1;
      cnt_waddr = ins_sid_q;
      cnt_wdata = cnt_rdata_q + NW'(1);
    end
  end

  // A constraint beyond the subscription's count always passes; an empty
  // subscription is knocked out by the nonzero-count flag taken at its first entry.
  assign pass    = !act2_q || (ok2_q && (ev_rdata_q >= lo2_q) && (ev_rdata_q <= hi2_q));
  assign acc_new = (first2_q ? nz2_q : acc_q) && pass;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[{ins_sid_q, KW'(cnt_rdata_q)}] <= ins_c_q;
    end
    tbl_rdata_q <= tbl_mem[{s_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem[AW'(attribute_i)] <= event_value_i;
    end
    ev_rdata_q <= ev_mem[ev_raddr];
  end

  // Payload and scan pipeline registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_sid_q    <= SW'(sub_id_i);
      ins_ok_q     <= (32'(sub_id_i) < MAX_SUBS);
      ins_c_q.attr <= attribute_i;
      ins_c_q.lo   <= low_bound_i;
      ins_c_q.hi   <= high_bound_i;
    end
    k1_q     <= k_q;
    first1_q <= (k_q == '0);
    last1_q  <= k_last;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    act2_q   <= (32'(k1_q) < 32'(cnt_rdata_q));
    nz2_q    <= (cnt_rdata_q != '0);
    ok2_q    <= (32'(tbl_rdata_q.attr) < NUM_ATTRS) && given_q[ev_raddr];
    lo2_q    <= tbl_rdata_q.lo;
    hi2_q    <= tbl_rdata_q.hi;
  end

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    k_d      = k_q;
    given_d  = given_q;
    count_d  = count_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    match_d  = match_q;
    status_d = status_q;
    if (v2_q) begin
      acc_d = acc_new;
      if (last2_q && acc_new) begin
        count_d = count_q + CNTW'(1);
      end
    end
    unique case (state_q)
      S_CLEAR: begin
        s_d = s_q + SW'(1);
        if (s_q == SW'(MAX_SUBS - 1)) begin
          s_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_INSERT) begin
            state_d = S_INS;
          end else begin
            if (ev_we) begin
              given_d[AW'(attribute_i)] = 1'b1;
            end
            if (last_i) begin
              s_d     = '0;
              k_d     = '0;
              count_d = '0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_INS: begin
        done_d   = 1'b1;
        match_d  = '0;
        status_d = ins_full ? ST_FULL : ST_INSERT_OK;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        k_d = k_q + KW'(1);
        if (k_last) begin
          k_d = '0;
          s_d = s_q + SW'(1);
          if (s_q == SW'(MAX_SUBS - 1)) begin
            s_d     = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          done_d   = 1'b1;
          match_d  = MatchW'(count_q);
          status_d = ST_EVENT;
          given_d  = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      s_q      <= '0;
      k_q      <= '0;
      given_q  <= '0;
      count_q  <= '0;
      acc_q    <= 1'b0;
      done_q   <= 1'b0;
      match_q  <= '0;
      status_q <= ST_INSERT_OK;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      s_q      <= s_d;
      k_q      <= k_d;
      given_q  <= given_d;
      count_q  <= count_d;
      acc_q    <= acc_d;
      done_q   <= done_d;
      match_q  <= match_d;
      status_q <= status_d;
      v1_q     <= (state_q == S_SCAN);
      v2_q     <= v1_q;
    end
  end

  assign done_o        = done_q;
  assign match_count_o = match_q;
  assign status_o      = status_q;

  // An insert is always answered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_INSERT) |=> ##1 done_o)
    else $error("insert result missing");

  // An event pair that does not close the event gives no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_EVENT && !last_i) |=> !done_o)
    else $error("result for an open event");

  // No result is given while the scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !done_o && !v2_q || !done_o)
    else $error("result during scan");

  // Insert results carry a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_EVENT) |-> (match_count_o == '0))
    else $error("nonzero count on insert result");

  // The event values are forgotten once the count has been given.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EVENT) |-> (given_q == '0))
    else $error("event values not cleared");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the interval subscription matcher. A scoreboard
// keeps its own copy of the constraint lists and the event values, predicts
// the result of every insert and every closing event pair and checks each done_o result against it.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import isub_pkg::*;

  localparam int SUBS         = MaxSubsDefault;
  localparam int CONS         = MaxConstraintsDefault;
  localparam int ATTRS        = NumAttrsDefault;
  localparam int RANDOM_WORDS = 1570;
  localparam int QUIET_TAIL   = 200;
  localparam int HOT_SUBS     = 48;
  localparam int FOCUS_ATTRS  = 8;
  // A full scan walks all SUBS * CONS entries, then drains the read pipeline.
  localparam int TAIL_CYCLES  = SUBS * CONS + 50;

  typedef struct {
    logic [MatchW-1:0]  count;
    logic [StatusW-1:0] status;
  } outcome_t;

  class interval_match_board;
    constr_t          held [SUBS][CONS];
    int unsigned      held_cnt [SUBS];
    logic [BoundW-1:0] ev_value [ATTRS];
    bit               ev_given [ATTRS];
    outcome_t         expected_q [$];
    int               errors;

    function new();
      foreach (held_cnt[i]) held_cnt[i] = 0;
      foreach (ev_given[i]) ev_given[i] = 1'b0;
      errors = 0;
    endfunction

    function bit sub_satisfied(int s);
      constr_t c;
      if (held_cnt[s] == 0) return 1'b0;
      for (int k = 0; k < held_cnt[s]; k++) begin
        c = held[s][k];
        if (c.attr >= ATTRS || !ev_given[c.attr]) return 1'b0;
        if (ev_value[c.attr] < c.lo || ev_value[c.attr] > c.hi) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Called for every word the block takes.
    function void note_word(logic cmd, logic [SubIdW-1:0] sid, logic [AttrW-1:0] attr,
                            logic [BoundW-1:0] lo, logic [BoundW-1:0] hi,
                            logic [BoundW-1:0] val, logic last);
      outcome_t r;
      int       total;
      if (cmd == CMD_INSERT) begin
        r.count = '0;
        if (sid >= SUBS || held_cnt[sid] >= CONS) begin
          r.status = ST_FULL;
        end else begin
          held[sid][held_cnt[sid]].attr = attr;
          held[sid][held_cnt[sid]].lo   = lo;
          held[sid][held_cnt[sid]].hi   = hi;
          held_cnt[sid]++;
          r.status = ST_INSERT_OK;
        end
        expected_q = {expected_q, r};
      end else begin
        if (attr < ATTRS) begin
          ev_value[attr] = val;
          ev_given[attr] = 1'b1;
        end
        if (last) begin
          total = 0;
          for (int s = 0; s < SUBS; s++) if (sub_satisfied(s)) total++;
          r.count  = MatchW'(total);
          r.status = ST_EVENT;
          expected_q = {expected_q, r};
          foreach (ev_given[i]) ev_given[i] = 1'b0;
        end
      end
    endfunction

    function void check_result(logic [MatchW-1:0] count, logic [StatusW-1:0] status);
      outcome_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending: match_count %0d status %0d",
                 $time, count, status);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (r.count !== count) begin
        $display("%0t: match_count expected %0d, got %0d", $time, r.count, count);
        errors++;
      end
      if (r.status !== status) begin
        $display("%0t: status expected %0d, got %0d", $time, r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic                cmd_i         = CMD_INSERT;
  logic [SubIdW-1:0]   sub_id_i      = '0;
  logic [AttrW-1:0]    attribute_i   = '0;
  logic [BoundW-1:0]   low_bound_i   = '0;
  logic [BoundW-1:0]   high_bound_i  = '0;
  logic [BoundW-1:0]   event_value_i = '0;
  logic                last_i        = 1'b0;
  logic                busy_o;
  logic                done_o;
  logic [MatchW-1:0]   match_count_o;
  logic [StatusW-1:0]  status_o;

  interval_match_board board;
  int                  words_sent = 0;
  bit                  idle_on    = 1'b1;

  interval_subscription_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .sub_id_i      (sub_id_i),
    .attribute_i   (attribute_i),
    .low_bound_i   (low_bound_i),
    .high_bound_i  (high_bound_i),
    .event_value_i (event_value_i),
    .last_i        (last_i),
    .done_o        (done_o),
    .match_count_o (match_count_o),
    .status_o      (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_result(match_count_o, status_o);
  end

  initial begin
    #250_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Presents one word and holds it until the block takes it; start_i stays
  // high so that a following word can go out back to back.
  task automatic put_word(input logic cmd, input logic [SubIdW-1:0] sid,
                          input logic [AttrW-1:0] attr, input logic [BoundW-1:0] lo,
                          input logic [BoundW-1:0] hi, input logic [BoundW-1:0] val,
                          input logic last);
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    sub_id_i      <= sid;
    attribute_i   <= attr;
    low_bound_i   <= lo;
    high_bound_i  <= hi;
    event_value_i <= val;
    last_i        <= last;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    board.note_word(cmd, sid, attr, lo, hi, val, last);
    words_sent++;
  endtask

  task automatic rest(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_rest();
    if (idle_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 5));
  endtask

  // Waits until every predicted result has come back.
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_q.size() != 0);
  endtask

  // The fields that a command ignores carry random values.
  task automatic insert_word(input int sid, input int attr, input int lo, input int hi);
    put_word(CMD_INSERT, SubIdW'(sid), AttrW'(attr), BoundW'(lo), BoundW'(hi),
             BoundW'($urandom), 1'($urandom_range(0, 1)));
    maybe_rest();
  endtask

  task automatic event_word(input int attr, input int val, input bit last);
    put_word(CMD_EVENT, SubIdW'($urandom), AttrW'(attr), BoundW'($urandom),
             BoundW'($urandom), BoundW'(val), last);
    maybe_rest();
  endtask

  function automatic int pick_sub();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, HOT_SUBS - 1)
                                      : $urandom_range(0, SUBS - 1);
  endfunction

  function automatic int focus_attr();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, ATTRS - 1)
                                       : $urandom_range(0, FOCUS_ATTRS - 1);
  endfunction

  function automatic logic [BoundW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return BoundW'($urandom);
    endcase
  endfunction

  // Mostly a value inside the interval, sometimes one just outside its edges.
  function automatic logic [BoundW-1:0] value_near(constr_t c);
    if (c.lo > c.hi) return BoundW'($urandom);
    case ($urandom_range(0, 9))
      0: return c.lo;
      1: return c.hi;
      2: return c.lo - 1'b1;
      3: return c.hi + 1'b1;
      default: return BoundW'($urandom_range(c.hi, c.lo));
    endcase
  endfunction

  task automatic insert_burst();
    logic [BoundW-1:0] lo;
    logic [BoundW-1:0] hi;
    int                width;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0: begin
          lo = BoundW'($urandom);
          hi = lo;
        end
        1: begin
          lo = BoundW'($urandom_range(1, 65535));
          hi = BoundW'($urandom_range(lo - 1, 0));
        end
        2: begin
          lo = BoundW'($urandom);
          hi = BoundW'($urandom);
        end
        3: begin
          lo = '0;
          hi = '1;
        end
        default: begin
          lo    = BoundW'($urandom);
          width = $urandom_range(0, 20000);
          hi    = (lo + width > 65535) ? 16'hFFFF : BoundW'(lo + width);
        end
      endcase
      insert_word(pick_sub(), focus_attr(), int'(lo), int'(hi));
    end
  endtask

  // An event built to satisfy one chosen subscription, with a few stray pairs
  // around it that may repeat an attribute and spoil the match.
  task automatic targeted_event();
    logic [AttrW-1:0]  attrs [$];
    logic [BoundW-1:0] vals [$];
    int                s;
    s = pick_sub();
    repeat ($urandom_range(0, 2)) begin
      attrs = {attrs, AttrW'(focus_attr())};
      vals  = {vals, random_value()};
    end
    for (int k = 0; k < board.held_cnt[s]; k++) begin
      attrs = {attrs, board.held[s][k].attr};
      vals  = {vals, value_near(board.held[s][k])};
    end
    if (attrs.size() == 0 || $urandom_range(0, 4) == 0) begin
      attrs = {attrs, AttrW'(focus_attr())};
      vals  = {vals, random_value()};
    end
    for (int i = 0; i < attrs.size(); i++) begin
      event_word(int'(attrs[i]), int'(vals[i]), i == attrs.size() - 1);
    end
  endtask

  initial begin
    int  base;
    bit  paused;
    int  pick;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One wide constraint on attribute 0 in every subscription, so that the
    // next event matches all of them.
    for (int s = 0; s < SUBS; s++) insert_word(s, 0, 0, 65535);
    event_word(0, int'($urandom), 1'b1);
    settle();

    insert_word(SUBS - 1, ATTRS - 1, 65535, 65535);
    insert_word(1, 5, 100, 50);
    insert_word(2, 3, 1000, 2000);
    insert_word(2, 4, 0, 0);
    event_word(0, 0, 1'b0);
    event_word(ATTRS - 1, 65535, 1'b0);
    event_word(3, 1500, 1'b0);
    event_word(4, 0, 1'b0);
    event_word(3, 2500, 1'b0);
    event_word(5, 75, 1'b1);
    // Attribute 0 is not given here, so nothing may match.
    event_word(3, 1500, 1'b1);
    event_word(0, 65535, 1'b0);
    event_word(ATTRS - 1, 0, 1'b1);
    for (int k = 1; k <= CONS; k++) insert_word(7, k, 0, 65535);
    settle();

    base   = words_sent;
    paused = 1'b0;
    while (words_sent - base < RANDOM_WORDS) begin
      idle_on = (RANDOM_WORDS - (words_sent - base) > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 58) begin
        insert_burst();
      end else if (pick < 93) begin
        targeted_event();
      end else begin
        event_word(focus_attr(), int'(random_value()), $urandom_range(0, 3) == 0);
      end
      if (!paused && words_sent - base >= RANDOM_WORDS / 2) begin
        settle();
        paused = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/isub_pkg.sv
hdl/interval_subscription_matcher.sv
tb/sv/testbench.sv
